[rtl/egd_pkg.sv]
package egd_pkg;

    localparam int unsigned WINDOW_W = 32;
    localparam int unsigned ZCOUNT_W = 5;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned VALUE_W  = 17;
    localparam int unsigned LENGTH_W = 6;

    localparam logic [CODE_W-2:0] MAG_MASK = 15'h7FFF;
    localparam logic [CODE_W-1:0] TOP_BIT  = 16'h8000;
    localparam logic [CODE_W-1:0] CODE_ONE = 16'h0001;

    // One decoded word as it travels from the decoder to the output register
    typedef struct packed {
        logic signed [VALUE_W-1:0]  decoded_value;
        logic        [LENGTH_W-1:0] bits_used;
        logic                       no_marker;
    } egd_result_t;

endpackage

[rtl/exp_golomb_decoder_unit.sv]
// Order-0 Exp-Golomb decoder: one 32-bit code window in, one decoded word out.
// Each word passes the input register, then the result register, with the
// trailing-zero count and bit reversal between them.
// Throughput: 1 word per cycle; the two register stages stall together only
// when both hold a word and out_ready is low.
// Reset: rst_n clears both stage valid flags asynchronously; payload is not reset.
module exp_golomb_decoder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [egd_pkg::WINDOW_W-1:0]         code_window,
    input  logic                                 signed_mode,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [egd_pkg::VALUE_W-1:0]   decoded_value,
    output logic [egd_pkg::LENGTH_W-1:0]         bits_used,
    output logic                                 no_marker
);
    import egd_pkg::*;

    // Input stage: captured window and mode
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [WINDOW_W-1:0] s1_window_reg;
    logic                s1_mode_reg;

    // Result stage
    logic                out_valid_reg;
    logic                out_valid_next;
    egd_result_t         res_reg;
    egd_result_t         res_comb;

    logic                adv_out;
    logic                take_in;
    logic                take_res;

    // The result register frees up when empty or when its word is taken;
    // the input register frees up when empty or when it can move forward.
    assign adv_out  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv_out;
    assign take_in  = in_valid && in_ready;
    assign take_res = s1_valid_reg && adv_out;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (adv_out)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the window until the decoder result can be registered
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_window_reg <= code_window;
            s1_mode_reg   <= signed_mode;
        end
    end

    egd_decode u_decode (
        .code_window (s1_window_reg),
        .signed_mode (s1_mode_reg),
        .result      (res_comb)
    );

    // Advance the decoded word into the output register
    always_ff @(posedge clk)
    begin
        if (take_res)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = res_reg.decoded_value;
    assign bits_used     = res_reg.bits_used;
    assign no_marker     = res_reg.no_marker;

`ifndef SYNTHESIS
    // An empty window must come out with zeroed result fields
    a_no_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_marker) |-> (bits_used == '0 && decoded_value == '0))
        else $error("no_marker word carries nonzero fields");

    // A real codeword always has odd length
    a_odd_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !no_marker) |-> bits_used[0])
        else $error("codeword length is even");

    // Both stages full and output stalled: input must be blocked
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while pipeline is full");
`endif

endmodule

[rtl/egd_tzc.sv]
module egd_tzc (
    input  logic [egd_pkg::WINDOW_W-1:0] window,
    output logic [egd_pkg::ZCOUNT_W-1:0] zeros,
    output logic                         all_zero
);
    import egd_pkg::*;

    logic [WINDOW_W-1:0] work;
    int unsigned         span;

    // Binary search: test the low half, drop it when empty, halve the span
    always_comb
    begin
        work  = window;
        zeros = '0;
        for (int s = ZCOUNT_W - 1; s >= 0; s--)
        begin
            span = 32'd1 << s;
            if ((work & ((WINDOW_W'(1) << span) - WINDOW_W'(1))) == '0)
            begin
                zeros[s] = 1'b1;
                work     = work >> span;
            end
        end
        all_zero = (window == '0);
    end

endmodule

[rtl/egd_decode.sv]
module egd_decode (
    input  logic [egd_pkg::WINDOW_W-1:0] code_window,
    input  logic                         signed_mode,
    output egd_pkg::egd_result_t         result
);
    import egd_pkg::*;

    logic [ZCOUNT_W-1:0] zeros;
    logic                all_zero;
    logic [WINDOW_W-1:0] info;
    logic [WINDOW_W-1:0] info_rev;
    logic [WINDOW_W-1:0] info_shift;
    logic [CODE_W-1:0]   code;
    logic [CODE_W-2:0]   mag;
    logic [CODE_W-1:0]   s16;
    logic [CODE_W-1:0]   u16;

    egd_tzc u_tzc (
        .window   (code_window),
        .zeros    (zeros),
        .all_zero (all_zero)
    );

    // Align the marker bit to bit 0, mirror, then pull the z+1 code bits down;
    // bits above z fall off the bottom of the shift and are dropped.
    always_comb
    begin
        info = code_window >> zeros;
        for (int i = 0; i < WINDOW_W; i++)
        begin
            info_rev[WINDOW_W-1-i] = info[i];
        end
        info_shift = info_rev >> (5'd31 - zeros);
        code       = info_shift[CODE_W-1:0];
    end

    always_comb
    begin
        u16 = code - CODE_ONE;
        mag = code[CODE_W-1:1] & MAG_MASK;
        s16 = code[0] ? (~{1'b0, mag} + CODE_ONE) : {1'b0, mag};
        if (zeros[ZCOUNT_W-1])
        begin
            s16 = s16 | TOP_BIT;
        end

        if (all_zero)
        begin
            result.decoded_value = '0;
            result.bits_used     = '0;
            result.no_marker     = 1'b1;
        end
        else
        begin
            result.decoded_value = signed_mode ? {s16[CODE_W-1], s16} : {1'b0, u16};
            result.bits_used     = {zeros, 1'b1};
            result.no_marker     = 1'b0;
        end
    end

endmodule

[test/tb.sv]
module tb;
    import egd_pkg::*;

    // Mode codes for signed_mode
    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // Marks a stimulus row whose expected word is written out in the table
    localparam logic FIXED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    localparam int unsigned IDLE_PCT       = 9;
    localparam int unsigned RANDOM_WORDS   = 1428;
    localparam int unsigned CALM_FIRST     = 400;
    localparam int unsigned CALM_LAST      = 750;
    localparam int unsigned PAUSE_AT       = 1000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Codewords with this many leading zeros or more take the long path
    localparam int unsigned LONG_ZEROS     = CODE_W;

    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic                smode;
        logic                fixed;
        egd_result_t         want;
    } probe_t;

    localparam int unsigned PROBE_COUNT = 23;

    // Directed rows: empty window, shortest and longest codewords, negative
    // zero, the boundary between short and long codewords, both modes.
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{32'h0000_0000, MODE_UNSIGNED, FIXED,   '{17'sd0,      6'd0,  1'b1}},
        '{32'h0000_0000, MODE_SIGNED,   FIXED,   '{17'sd0,      6'd0,  1'b1}},
        '{32'h0000_0001, MODE_UNSIGNED, FIXED,   '{17'sd0,      6'd1,  1'b0}},
        '{32'h0000_0001, MODE_SIGNED,   FIXED,   '{17'sd0,      6'd1,  1'b0}},
        '{32'hFFFF_FFFF, MODE_UNSIGNED, FIXED,   '{17'sd0,      6'd1,  1'b0}},
        '{32'hFFFF_FFFF, MODE_SIGNED,   FIXED,   '{17'sd0,      6'd1,  1'b0}},
        '{32'h0000_0002, MODE_UNSIGNED, FIXED,   '{17'sd1,      6'd3,  1'b0}},
        '{32'h0000_0002, MODE_SIGNED,   FIXED,   '{17'sd1,      6'd3,  1'b0}},
        '{32'h0000_0006, MODE_UNSIGNED, FIXED,   '{17'sd2,      6'd3,  1'b0}},
        '{32'h0000_0006, MODE_SIGNED,   FIXED,   '{-17'sd1,     6'd3,  1'b0}},
        '{32'h8000_0000, MODE_UNSIGNED, FIXED,   '{17'sd65535,  6'd63, 1'b0}},
        '{32'h8000_0000, MODE_SIGNED,   FIXED,   '{-17'sd32768, 6'd63, 1'b0}},
        '{32'h0001_0000, MODE_UNSIGNED, FIXED,   '{17'sd65535,  6'd33, 1'b0}},
        '{32'h0001_0000, MODE_SIGNED,   FIXED,   '{-17'sd32768, 6'd33, 1'b0}},
        '{32'h0000_8000, MODE_UNSIGNED, PREDICT, '0},
        '{32'h0000_8000, MODE_SIGNED,   PREDICT, '0},
        '{32'hFFFF_0000, MODE_UNSIGNED, PREDICT, '0},
        '{32'hFFFF_0000, MODE_SIGNED,   PREDICT, '0},
        '{32'hFFFF_8000, MODE_SIGNED,   PREDICT, '0},
        '{32'hAAAA_AAAA, MODE_UNSIGNED, PREDICT, '0},
        '{32'h5555_5554, MODE_SIGNED,   PREDICT, '0},
        '{32'hC000_0000, MODE_SIGNED,   PREDICT, '0},
        '{32'h7FFF_FFFE, MODE_UNSIGNED, PREDICT, '0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [WINDOW_W-1:0]        code_window;
    logic                       signed_mode;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [VALUE_W-1:0]  decoded_value;
    logic [LENGTH_W-1:0]        bits_used;
    logic                       no_marker;

    // Decoded words still owed by the block, oldest first
    egd_result_t owed_words [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    // High while neither side idles
    logic        calm;

    exp_golomb_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_window   (code_window),
        .signed_mode   (signed_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .decoded_value (decoded_value),
        .bits_used     (bits_used),
        .no_marker     (no_marker)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decode one window the way the block should: count the zeros below the
    // marker bit, gather the marker and the bits above it with the first one
    // landing on top, keep 16 bits, then map to the unsigned or signed value.
    function automatic egd_result_t decode_codeword(input logic [WINDOW_W-1:0] window,
                                                    input logic smode);
        egd_result_t         res;
        int unsigned         zeros;
        int unsigned         i;
        logic [WINDOW_W-1:0] suffix;
        logic [CODE_W-1:0]   info;
        logic [CODE_W-1:0]   word16;
        logic [CODE_W-2:0]   mag;
        res = '0;
        if (window == '0)
        begin
            res.no_marker = 1'b1;
            return res;
        end
        zeros = 0;
        while (!window[zeros])
            zeros++;
        suffix = window >> zeros;
        info = '0;
        for (i = 0; i <= zeros; i++)
            info = {info[CODE_W-2:0], suffix[i]};
        res.bits_used = LENGTH_W'(2 * zeros + 1);
        if (smode == MODE_UNSIGNED)
            word16 = info - CODE_ONE;
        else
        begin
            mag = info[CODE_W-1:1] & MAG_MASK;
            word16 = info[0] ? (CODE_W'(0) - {1'b0, mag}) : {1'b0, mag};
            // Long codewords lose their top bits; force the sign bit
            if (zeros >= LONG_ZEROS)
                word16 = word16 | TOP_BIT;
        end
        res.decoded_value = (smode == MODE_SIGNED) ? {word16[CODE_W-1], word16}
                                                   : {1'b0, word16};
        return res;
    endfunction

    // Present one window, hold it until the block takes it, then log what
    // the block owes for it. Idle first now and then unless calm.
    task automatic send_window(input logic [WINDOW_W-1:0] window, input logic smode,
                               input logic fixed, input egd_result_t want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_window <= window;
        signed_mode <= smode;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        owed_words.push_back(fixed ? want : decode_codeword(window, smode));
    endtask

    // Drop ready now and then, except during the calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Match each decoded word against the oldest one owed
    always @(posedge clk)
    begin
        egd_result_t want;
        if (out_valid && out_ready)
        begin
            if (owed_words.size() == 0)
            begin
                $display("%0t: decoded word arrived with none owed: value %0d length %0d flag %0b",
                         $time, decoded_value, bits_used, no_marker);
                mismatches++;
            end
            else
            begin
                want = owed_words.pop_front();
                if (decoded_value !== want.decoded_value)
                begin
                    $display("%0t: decoded_value expected %0d actual %0d",
                             $time, want.decoded_value, decoded_value);
                    mismatches++;
                end
                if (bits_used !== want.bits_used)
                begin
                    $display("%0t: bits_used expected %0d actual %0d",
                             $time, want.bits_used, bits_used);
                    mismatches++;
                end
                if (no_marker !== want.no_marker)
                begin
                    $display("%0t: no_marker expected %0b actual %0b",
                             $time, want.no_marker, no_marker);
                    mismatches++;
                end
            end
        end
    end

    // Give up when neither side has moved a word for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [WINDOW_W-1:0] window;
        logic                smode;
        int unsigned         zeros;
        int unsigned         pick;
        int unsigned         n;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        code_window  = '0;
        signed_mode  = MODE_UNSIGNED;
        calm         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (n = 0; n < PROBE_COUNT; n++)
            send_window(PROBES[n].window, PROBES[n].smode, PROBES[n].fixed, PROBES[n].want);

        // Random part: mostly well-formed codewords with the marker at a
        // uniformly chosen position and random bits above it, plus raw
        // noise and the occasional empty window.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == CALM_FIRST)
                calm <= 1'b1;
            else if (n == CALM_LAST)
                calm <= 1'b0;
            if (n == PAUSE_AT)
            begin
                // Hold off until every owed word has come back
                in_valid <= 1'b0;
                @(posedge clk);
                while (owed_words.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                window = '0;
            else if (pick < 8)
                window = $urandom;
            else
            begin
                zeros  = $urandom_range(0, WINDOW_W - 1);
                window = ($urandom | 32'h1) << zeros;
            end
            smode = 1'($urandom_range(0, 1));
            send_window(window, smode, PREDICT, '0);
        end

        // Drain: wait for every owed word, then a few more cycles
        in_valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
